[rtl/nwm_pkg.sv]
// ----------------------------------------------------------------------------
// nwm_pkg: shared definitions for the nth weekday of month block
// Widths, register indexes, stage control and calendar helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nwm_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 14;
  localparam int unsigned WdW     = 3;
  localparam int unsigned OpW     = 3;
  localparam int unsigned DayW    = 5;
  localparam int unsigned YyW     = 15;
  localparam int unsigned SumW    = 15;
  localparam int unsigned NStages = 5;

  // Reciprocal of 100 scaled by 2^19; exact for values below 2^15.
  localparam logic [12:0] Recip100 = 13'd5243;
  localparam int unsigned RecipSh  = 19;

  localparam logic [YearW-1:0]  YearReset  = 14'd2000;
  localparam logic [MonthW-1:0] MonthReset = 4'd1;

  localparam logic [CfgIdxW-1:0] REG_YEAR  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MONTH = 2'd1;

  localparam logic [OpW-1:0] OP_TEENTH = 3'd0;
  localparam logic [OpW-1:0] OP_FIRST  = 3'd1;
  localparam logic [OpW-1:0] OP_LAST   = 3'd5;

  // Per-stage valid and load enable, from the flow control to the datapath.
  typedef struct packed {
    logic [NStages-1:0] vld;
    logic [NStages-1:0] en;
  } ctl_t;

  // Hand-off from the year datapath to the day datapath.
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [DayW-1:0] dim;
    logic [WdW-1:0]  wd;
    logic [OpW-1:0]  op;
    logic            err;
  } yr_res_t;

  function automatic logic [2:0] month_offset(input logic [MonthW-1:0] m);
    logic [2:0] r;
    case (m)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Reduces a value below 14 modulo 7.
  function automatic logic [2:0] mod7_small(input logic [3:0] x);
    logic [3:0] r;
    r = (x >= 4'd7) ? (x - 4'd7) : x;
    return r[2:0];
  endfunction

endpackage

[rtl/nwm_flow.sv]
// ----------------------------------------------------------------------------
// nwm_flow: pipeline flow control
// Valid bits per stage and load enables; bubbles are squeezed out on a stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nwm_flow (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output nwm_pkg::ctl_t ctl_o
);
  import nwm_pkg::*;

  logic [NStages-1:0] vld_q, vld_d;
  logic [NStages:0]   rdy;

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    rdy[NStages] = out_ready_i;
    for (int k = NStages - 1; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  // The first stage takes the input valid; every later stage takes the valid
  // of the stage before it.
  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NStages; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = rdy[0];
  assign ctl_o.vld  = vld_q;
  assign ctl_o.en   = rdy[NStages-1:0];

endmodule

[rtl/nwm_year.sv]
// ----------------------------------------------------------------------------
// nwm_year: year and month arithmetic, stages 0 to 2
// Shifted year, century quotients, leap flag, month length and weekday sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nwm_year (
  input  logic                          clk_i,
  input  nwm_pkg::ctl_t                 ctl_i,
  input  logic [nwm_pkg::YearW-1:0]     year_i,
  input  logic [nwm_pkg::MonthW-1:0]    month_i,
  input  logic [nwm_pkg::WdW-1:0]       weekday_i,
  input  logic [nwm_pkg::OpW-1:0]       op_i,
  output nwm_pkg::yr_res_t              res_o
);
  import nwm_pkg::*;

  // Stage 0: operands and the year moved forward by 400 (back one for Jan/Feb).
  logic [YyW-1:0]    yy0_q;
  logic [YearW-1:0]  year0_q;
  logic [MonthW-1:0] mon0_q;
  logic [WdW-1:0]    wd0_q;
  logic [OpW-1:0]    op0_q;
  logic              err0_q;
  logic [YyW-1:0]    yy0_d;
  logic              err0_d;

  assign yy0_d  = {1'b0, year_i} + YyW'(400) - ((month_i < 4'd3) ? YyW'(1) : YyW'(0));
  assign err0_d = (op_i > OP_LAST) || (weekday_i > 3'd6) ||
                  (month_i == 4'd0) || (month_i > 4'd12);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      yy0_q   <= yy0_d;
      year0_q <= year_i;
      mon0_q  <= month_i;
      wd0_q   <= weekday_i;
      op0_q   <= op_i;
      err0_q  <= err0_d;
    end
  end

  // Stage 1: quotients by 100 through reciprocal multiplication.
  logic [27:0]       prod_yy;
  logic [26:0]       prod_yr;
  logic [8:0]        q100_q;
  logic [7:0]        cy_q;
  logic [YyW-1:0]    yy1_q;
  logic [YearW-1:0]  year1_q;
  logic [MonthW-1:0] mon1_q;
  logic [WdW-1:0]    wd1_q;
  logic [OpW-1:0]    op1_q;
  logic              err1_q;

  assign prod_yy = {13'd0, yy0_q} * {15'd0, Recip100};
  assign prod_yr = {13'd0, year0_q} * {14'd0, Recip100};

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      q100_q  <= prod_yy[RecipSh +: 9];
      cy_q    <= prod_yr[RecipSh +: 8];
      yy1_q   <= yy0_q;
      year1_q <= year0_q;
      mon1_q  <= mon0_q;
      wd1_q   <= wd0_q;
      op1_q   <= op0_q;
      err1_q  <= err0_q;
    end
  end

  // Stage 2: weekday sum, leap year and length of the month.
  logic [15:0]      sum_d;
  logic [YearW-1:0] cy100;
  logic             leap;
  logic [DayW-1:0]  dim_d;
  yr_res_t          res_q;

  assign sum_d = {1'b0, yy1_q} + {3'b0, yy1_q[YyW-1:2]} - {7'd0, q100_q}
               + {9'd0, q100_q[8:2]} + {13'd0, month_offset(mon1_q)} + 16'd1;
  assign cy100 = {6'd0, cy_q} * 14'd100;
  assign leap  = (year1_q[1:0] == 2'b00) && ((cy100 != year1_q) || (cy_q[1:0] == 2'b00));

  always_comb begin
    case (mon1_q)
      4'd2:                      dim_d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   dim_d = 5'd30;
      default:                   dim_d = 5'd31;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      res_q.sum <= sum_d[SumW-1:0];
      res_q.dim <= dim_d;
      res_q.wd  <= wd1_q;
      res_q.op  <= op1_q;
      res_q.err <= err1_q;
    end
  end

  assign res_o = res_q;

endmodule

[rtl/nwm_day.sv]
// ----------------------------------------------------------------------------
// nwm_day: weekday and day-of-month selection, stages 3 and 4
// Reduces the weekday sum modulo 7, then picks the day for the selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nwm_day (
  input  logic                       clk_i,
  input  nwm_pkg::ctl_t              ctl_i,
  input  nwm_pkg::yr_res_t           res_i,
  output logic [nwm_pkg::DayW-1:0]   day_o,
  output logic                       status_o
);
  import nwm_pkg::*;

  // Stage 3: octal digits fold modulo 7 since 8 is 1 modulo 7.
  logic [5:0]      dsum;
  logic [3:0]      fold;
  logic [2:0]      f_q;
  logic [DayW-1:0] dim3_q;
  logic [WdW-1:0]  wd3_q;
  logic [OpW-1:0]  op3_q;
  logic            err3_q;

  assign dsum = {3'd0, res_i.sum[2:0]} + {3'd0, res_i.sum[5:3]} + {3'd0, res_i.sum[8:6]}
              + {3'd0, res_i.sum[11:9]} + {3'd0, res_i.sum[14:12]};
  assign fold = {1'b0, dsum[2:0]} + {1'b0, dsum[5:3]};

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[3]) begin
      f_q    <= mod7_small(fold);
      dim3_q <= res_i.dim;
      wd3_q  <= res_i.wd;
      op3_q  <= res_i.op;
      err3_q <= res_i.err;
    end
  end

  // Stage 4: day for teenth, last or nth occurrence.
  logic [2:0]      w13, dlm, wl, t_off, l_off, n_off;
  logic [OpW-1:0]  nth;
  logic [DayW-1:0] day_d;
  logic [DayW-1:0] day_q;
  logic            st_q;

  assign w13   = mod7_small({1'b0, f_q} + 4'd5);
  assign t_off = mod7_small({1'b0, wd3_q} + 4'd7 - {1'b0, w13});
  assign n_off = mod7_small({1'b0, wd3_q} + 4'd7 - {1'b0, f_q});
  assign nth   = op3_q - OP_FIRST;

  // Last day of the month minus one, modulo 7.
  always_comb begin
    case (dim3_q)
      5'd28:   dlm = 3'd6;
      5'd29:   dlm = 3'd0;
      5'd30:   dlm = 3'd1;
      default: dlm = 3'd2;
    endcase
  end

  assign wl    = mod7_small({1'b0, f_q} + {1'b0, dlm});
  assign l_off = mod7_small({1'b0, wl} + 4'd7 - {1'b0, wd3_q});

  always_comb begin
    if (err3_q) begin
      day_d = '0;
    end else if (op3_q == OP_TEENTH) begin
      day_d = 5'd13 + {2'd0, t_off};
    end else if (op3_q == OP_LAST) begin
      day_d = dim3_q - {2'd0, l_off};
    end else begin
      day_d = 5'd1 + {2'd0, n_off} + ({2'd0, nth} * 5'd7);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[4]) begin
      day_q <= day_d;
      st_q  <= err3_q;
    end
  end

  assign day_o    = day_q;
  assign status_o = st_q;

endmodule

[rtl/nth_weekday_of_month.sv]
// ----------------------------------------------------------------------------
// nth_weekday_of_month: day of month of the nth weekday, Gregorian calendar
// Five pipeline stages register an accepted input transaction up to its result.
// Throughput: one transaction per cycle while the output is not stalled.
// Reset: pipeline empties; year resets to 2000 and month to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The year and month registers are written over the configuration channel,
// which is always ready. Each input transaction carries a weekday and a
// selector (teenth, first to fourth, last); the result is the day of the
// month, or day 0 with status 1 for an illegal selector, weekday or month.
//
// Pipeline:
//   stage 0  shifted year and error check
//   stage 1  quotients by 100 via reciprocal multiplication
//   stage 2  weekday sum of the first of the month, leap flag, month length
//   stage 3  weekday of the first, modulo 7 by octal digit folding
//   stage 4  day selection; this is the output register
// Every stage has its own valid bit, and a stage loads whenever it is empty
// or the stage after it moves, so input is still taken while a finished
// result waits at the output as long as a bubble exists somewhere upstream.

module nth_weekday_of_month (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nwm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [nwm_pkg::CfgW-1:0]      cfg_data_i,
  // Query channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [nwm_pkg::WdW-1:0]       weekday_i,
  input  logic [nwm_pkg::OpW-1:0]       op_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [nwm_pkg::DayW-1:0]      day_of_month_o,
  output logic                          status_o
);
  import nwm_pkg::*;

  logic [YearW-1:0]  year_q;
  logic [MonthW-1:0] month_q;
  ctl_t              ctl;
  yr_res_t           yr_res;

  // Writes to an index beyond the register list are accepted and dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q  <= YearReset;
      month_q <= MonthReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_YEAR:  year_q  <= cfg_data_i[YearW-1:0];
        REG_MONTH: month_q <= cfg_data_i[MonthW-1:0];
        default:   ;
      endcase
    end
  end

  // Valid bits and stage enables.
  nwm_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  // Year and month arithmetic. The configuration is sampled when the
  // transaction enters, so it travels with the query.
  nwm_year u_year (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .year_i    (year_q),
    .month_i   (month_q),
    .weekday_i (weekday_i),
    .op_i      (op_i),
    .res_o     (yr_res)
  );

  // Weekday of the first and final day selection.
  nwm_day u_day (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .res_i    (yr_res),
    .day_o    (day_of_month_o),
    .status_o (status_o)
  );

  assign out_valid_o = ctl.vld[NStages-1];

endmodule

[tb/nth_weekday_of_month_test.sv]
// ----------------------------------------------------------------------------
// nth_weekday_of_month_test: self-checking bench for the nth weekday block
// Drives calendar settings and weekday queries with random pacing, predicts
// each day of month independently and compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nwm_check_pkg;

  import nwm_pkg::*;

  localparam logic [WdW-1:0] SUNDAY     = 3'd0;
  localparam logic [WdW-1:0] MONDAY     = 3'd1;
  localparam logic [WdW-1:0] TUESDAY    = 3'd2;
  localparam logic [WdW-1:0] WEDNESDAY  = 3'd3;
  localparam logic [WdW-1:0] THURSDAY   = 3'd4;
  localparam logic [WdW-1:0] FRIDAY     = 3'd5;
  localparam logic [WdW-1:0] SATURDAY   = 3'd6;
  localparam logic [WdW-1:0] NO_WEEKDAY = 3'd7;

  localparam logic [OpW-1:0] OP_SECOND  = 3'd2;
  localparam logic [OpW-1:0] OP_THIRD   = 3'd3;
  localparam logic [OpW-1:0] OP_FOURTH  = 3'd4;
  localparam logic [OpW-1:0] OP_BAD_LO  = 3'd6;
  localparam logic [OpW-1:0] OP_BAD_HI  = 3'd7;

  localparam logic [CfgIdxW-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE3 = 2'd3;

  typedef struct packed {
    logic [DayW-1:0] day;
    logic            status;
  } day_answer_t;

  class weekday_scoreboard;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    day_answer_t       pending[$];
    int unsigned       mismatches;
    int unsigned       month_shift[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    int unsigned       month_len[12]   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    function new();
      // Values after reset: January 2000.
      year       = 14'd2000;
      month      = 4'd1;
      mismatches = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        REG_YEAR:  year  = data[YearW-1:0];
        REG_MONTH: month = data[MonthW-1:0];
        default: ;
      endcase
    endfunction

    function day_answer_t weekday_day(logic [WdW-1:0] wd, logic [OpW-1:0] sel);
      day_answer_t ans;
      int unsigned yr, mon, w, s, days, sy, first_wd;
      bit          leap;
      yr         = year;
      mon        = month;
      w          = wd;
      s          = sel;
      ans.day    = '0;
      ans.status = 1'b1;
      if (sel > OP_LAST || wd > SATURDAY || mon < 1 || mon > 12) begin
        return ans;
      end
      leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      days = (mon == 2) ? (leap ? 29 : 28) : month_len[mon - 1];
      // A shift of 400 years keeps the weekday and keeps year 0 positive.
      sy = yr + 400 - ((mon < 3) ? 1 : 0);
      first_wd = (sy + sy / 4 - sy / 100 + sy / 400 + month_shift[mon - 1] + 1) % 7;
      ans.status = 1'b0;
      case (sel)
        OP_TEENTH: ans.day = 5'(13 + (w + 7 - (first_wd + 12) % 7) % 7);
        OP_LAST:   ans.day = 5'(days - ((first_wd + days - 1) % 7 + 7 - w) % 7);
        default:   ans.day = 5'(1 + (w + 7 - first_wd) % 7 + 7 * (s - 1));
      endcase
      return ans;
    endfunction

    function void note_query(logic [WdW-1:0] wd, logic [OpW-1:0] sel);
      pending.push_back(weekday_day(wd, sel));
    endfunction

    function void check_result(logic [DayW-1:0] day, logic status);
      day_answer_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, day %0d status %0d", $time, day, status);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (want.day !== day) begin
        $display("%0t: day_of_month expected %0d actual %0d", $time, want.day, day);
        mismatches++;
      end
      if (want.status !== status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        mismatches++;
      end
    endfunction
  endclass

endpackage

module nth_weekday_of_month_test;

  import nwm_pkg::*;
  import nwm_check_pkg::*;

  // Roughly this many query transactions are sent before the run winds down.
  localparam int unsigned ItemTarget = 1550;
  // The run is declared hung well past the slowest legal pacing.
  localparam int unsigned CycleLimit = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [WdW-1:0]      weekday_i;
  logic [OpW-1:0]      op_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [DayW-1:0]     day_of_month_o;
  logic                status_o;

  weekday_scoreboard   sb;
  int unsigned         queries_sent;
  int unsigned         burst_left;
  int unsigned         cycle_count;
  int unsigned         stall_mode;
  int unsigned         stall_left;

  nth_weekday_of_month uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .weekday_i      (weekday_i),
    .op_i           (op_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .day_of_month_o (day_of_month_o),
    .status_o       (status_o)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // The watchdog counts every cycle so that a hung handshake still ends the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver switches between stall patterns: always ready, coin flip,
  // mostly stalled and a strict alternation. Each pattern holds for a random
  // stretch, so back-pressure lands on every pipeline phase and there are
  // also long runs with none at all.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= $urandom_range(0, 1) == 1;
      2:       out_ready_i <= $urandom_range(0, 3) == 0;
      default: out_ready_i <= cycle_count[0];
    endcase
  end

  // Every result transaction is checked against the oldest prediction. The
  // handshake is sampled on the edge, before any driven input changes.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(day_of_month_o, status_o);
    end
  end

  // One register write transaction. The valid is left high so that writes can
  // follow back to back; the caller lowers it when the burst of writes is done.
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    sb.set_register(idx, data);
  endtask

  // One query transaction. The sender works in bursts: when a burst is used up,
  // valid may drop for a random gap before the next burst starts. Now and then
  // a long burst gives a stretch with no sender idling at all.
  task automatic send_query(input logic [WdW-1:0] wd, input logic [OpW-1:0] sel);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    weekday_i  <= wd;
    op_i       <= sel;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    sb.note_query(wd, sel);
    queries_sent++;
    burst_left--;
  endtask

  // The sender holds off until every predicted result has been seen, then
  // lets the pipeline settle. Registers are only written after this.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (NStages + 2) @(posedge clk_i);
  endtask

  task automatic set_calendar(input logic [YearW-1:0] yr, input logic [MonthW-1:0] mon);
    drain();
    write_register(REG_YEAR, yr);
    write_register(REG_MONTH, {10'd0, mon});
    cfg_valid_i <= 1'b0;
  endtask

  // A random calendar setting followed by a batch of random queries. Years
  // mostly fall in the usual range, with whole centuries to exercise the leap
  // exceptions and any 14-bit value now and then. February is favored, and
  // a share of months lies outside 1 to 12. Some phases also write a spare
  // register index, which must leave both registers untouched, or put junk
  // in the unused upper bits of the month write.
  task automatic random_phase();
    logic [YearW-1:0]  yr;
    logic [MonthW-1:0] mon;
    logic [9:0]        junk;
    logic [WdW-1:0]    wd;
    logic [OpW-1:0]    sel;
    int unsigned       pick;
    int unsigned       n;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      yr = 14'($urandom_range(1900, 9999));
    end else if (pick < 8) begin
      yr = 14'($urandom_range(0, 163) * 100);
    end else begin
      yr = 14'($urandom_range(0, 16383));
    end
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      mon = 4'd2;
    end else if (pick < 8) begin
      mon = 4'($urandom_range(1, 12));
    end else begin
      mon = 4'($urandom_range(0, 15));
    end
    junk = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'd0;
    drain();
    if ($urandom_range(0, 4) != 0) begin
      write_register(REG_YEAR, yr);
    end
    write_register(REG_MONTH, {junk, mon});
    if ($urandom_range(0, 4) == 0) begin
      write_register(($urandom_range(0, 1) == 1) ? REG_SPARE2 : REG_SPARE3, 14'($urandom));
    end
    cfg_valid_i <= 1'b0;
    n = $urandom_range(12, 40);
    repeat (n) begin
      wd  = ($urandom_range(0, 9) == 0) ? NO_WEEKDAY : 3'($urandom_range(0, 6));
      sel = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      send_query(wd, sel);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    weekday_i    = '0;
    op_i         = '0;
    out_ready_i  = 1'b0;
    cycle_count  = 0;
    stall_mode   = 0;
    stall_left   = 0;
    queries_sent = 0;
    burst_left   = 0;
    sb           = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed queries against the reset setting, January 2000: every
    // selector, both illegal selectors, the weekday extremes and the
    // nonexistent weekday.
    send_query(SUNDAY, OP_TEENTH);
    send_query(SATURDAY, OP_TEENTH);
    send_query(SATURDAY, OP_FIRST);
    send_query(MONDAY, OP_SECOND);
    send_query(TUESDAY, OP_THIRD);
    send_query(WEDNESDAY, OP_FOURTH);
    send_query(THURSDAY, OP_LAST);
    send_query(SUNDAY, OP_LAST);
    send_query(FRIDAY, OP_BAD_LO);
    send_query(SATURDAY, OP_BAD_HI);
    send_query(NO_WEEKDAY, OP_FIRST);
    send_query(NO_WEEKDAY, OP_BAD_HI);

    // Leap February, including spare-index writes that must be ignored.
    drain();
    write_register(REG_YEAR, 14'd2000);
    write_register(REG_MONTH, 14'd2);
    write_register(REG_SPARE2, 14'h3fff);
    write_register(REG_SPARE3, 14'h3fff);
    cfg_valid_i <= 1'b0;
    send_query(TUESDAY, OP_LAST);
    send_query(SATURDAY, OP_FOURTH);

    // A century that is not a leap year, then year 0 and the largest year.
    set_calendar(14'd1900, 4'd2);
    send_query(WEDNESDAY, OP_LAST);
    set_calendar(14'd0, 4'd1);
    send_query(SUNDAY, OP_FIRST);
    set_calendar(14'd16383, 4'd12);
    send_query(SATURDAY, OP_TEENTH);
    send_query(FRIDAY, OP_LAST);
    set_calendar(14'd9999, 4'd3);
    send_query(MONDAY, OP_FIRST);

    // Months that do not exist give the error status for any query.
    set_calendar(14'd2024, 4'd0);
    send_query(MONDAY, OP_FIRST);
    set_calendar(14'd2024, 4'd13);
    send_query(SUNDAY, OP_TEENTH);
    set_calendar(14'd2024, 4'd15);
    send_query(SATURDAY, OP_LAST);

    while (queries_sent < ItemTarget) begin
      random_phase();
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/nwm_pkg.sv
rtl/nwm_flow.sv
rtl/nwm_year.sv
rtl/nwm_day.sv
rtl/nth_weekday_of_month.sv
tb/nth_weekday_of_month_test.sv
